### hdl/vdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex deduplication package
// Shared sizes, payload structs, codes and the tolerant attribute compare.
// ----------------------------------------------------------------------------
package vdd_pkg;

    localparam int MAX_UNIQUE  = 1024;
    localparam int JOINT_SLOTS = 2;
    localparam int ATTR_SLOTS  = 11 + 2 * JOINT_SLOTS;
    localparam int ATTR_W      = 64;
    localparam int IDX_W       = $clog2(MAX_UNIQUE);
    localparam int CNT_W       = 11;
    localparam int SLOT_W      = $clog2(ATTR_SLOTS);
    localparam int AC_W        = 5;
    localparam int TOL_W       = 20;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(24);
    localparam logic [AC_W-1:0]  AC_SAT    = AC_W'(31);
    localparam logic [AC_W-1:0]  AC_FULL   = AC_W'(ATTR_SLOTS);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_UNIQUE);

    typedef logic [ATTR_SLOTS-1:0][ATTR_W-1:0] row_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_COUNT = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [ATTR_W-1:0] attr_bits;
        logic              end_of_vertex;
        logic              new_mesh;
    } vdd_in_t;

    typedef struct packed {
        logic [CNT_W-1:0] vertex_index;
        logic             is_new;
        logic [CNT_W-1:0] unique_count;
        status_t          status;
    } vdd_out_t;

    function automatic logic attr_match(input logic [ATTR_W-1:0] a,
                                        input logic [ATTR_W-1:0] b,
                                        input logic [TOL_W-1:0]  tol);
        logic [ATTR_W-1:0] d;
        logic [ATTR_W-1:0] nd;
        logic [ATTR_W-1:0] tol_w;
        d     = a - b;
        nd    = b - a;
        tol_w = {{(ATTR_W - TOL_W){1'b0}}, tol};
        if (a[ATTR_W-1] != b[ATTR_W-1])
            return ((a[ATTR_W-2:0] | b[ATTR_W-2:0]) == '0);
        else
            return (d <= tol_w) || (nd <= tol_w);
    endfunction

endpackage

### hdl/vdd_row_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Row compare lanes
// Compares every attribute of a stored row with the gathered vertex, one
// lane per attribute, and registers the lane results.
// ----------------------------------------------------------------------------
module vdd_row_match (
    input  logic                        clk,
    input  vdd_pkg::row_t               row,
    input  vdd_pkg::row_t               probe,
    input  logic [vdd_pkg::TOL_W-1:0]   tol,
    output logic                        hit
);
    import vdd_pkg::*;

    logic [ATTR_SLOTS-1:0] lane_next;
    logic [ATTR_SLOTS-1:0] lane_reg;

    always_comb
    begin
        for (int k = 0; k < ATTR_SLOTS; k++)
        begin
            lane_next[k] = attr_match(probe[k], row[k], tol);
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg <= lane_next;
    end

    assign hit = &lane_reg;

endmodule

### hdl/vertex_dedup_ulp_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex deduplication with ULP-tolerant match
// Gathers one vertex per group of attribute transactions, scans the unique
// row memory one full row per cycle and returns the first matching index,
// or appends the vertex as a new row; it reports a bad attribute count or
// a full table in the status. An end-of-vertex transaction with a bad count
// or an empty table goes straight to the result; otherwise the scan reads
// one row of the single-port row memory per cycle into the read register,
// and the lanes register their compare. Reset clears counts, state and the
// result valid flag; the row memory holds no reset value and needs no sweep.
// ----------------------------------------------------------------------------
module vertex_dedup_ulp_match (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       vtx_valid,
    output logic                       vtx_stall,
    input  vdd_pkg::vdd_in_t           vtx,
    output logic                       res_valid,
    input  logic                       res_stall,
    output vdd_pkg::vdd_out_t          res,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [vdd_pkg::TOL_W-1:0]  cfg_data
);
    import vdd_pkg::*;

    state_t            state_reg, state_next;
    logic [AC_W-1:0]   attr_cnt_reg, attr_cnt_next;
    logic [CNT_W-1:0]  stored_count_reg, stored_count_next;
    logic [CNT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic [TOL_W-1:0]  tol_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s2_valid_reg, s2_valid_next;
    logic [IDX_W-1:0]  s2_idx_reg;
    vdd_out_t          pend_reg, pend_next;
    logic              pend_append_reg, pend_append_next;
    logic              res_valid_reg, res_valid_next;
    vdd_out_t          res_reg, res_next;

    row_t              buf_reg;
    logic              buf_we;
    logic [SLOT_W-1:0] buf_slot;

    row_t              row_mem [MAX_UNIQUE];
    row_t              rd_data_reg;
    logic              rd_en;
    logic              wr_en;
    logic              row_hit;
    logic              out_free;

    logic [AC_W-1:0]   ac;
    logic [AC_W-1:0]   ac_inc;
    logic [CNT_W-1:0]  cnt_base;

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    vdd_row_match u_row_match (
        .clk   (clk),
        .row   (rd_data_reg),
        .probe (buf_reg),
        .tol   (tol_reg),
        .hit   (row_hit)
    );

    always_comb
    begin
        ac       = vtx.new_mesh ? '0 : attr_cnt_reg;
        ac_inc   = (ac < AC_SAT) ? ac + AC_W'(1) : AC_SAT;
        cnt_base = vtx.new_mesh ? '0 : stored_count_reg;
        buf_slot = ac[SLOT_W-1:0];
    end

    always_comb
    begin
        state_next        = state_reg;
        attr_cnt_next     = attr_cnt_reg;
        stored_count_next = stored_count_reg;
        scan_cnt_next     = scan_cnt_reg;
        pend_next         = pend_reg;
        pend_append_next  = pend_append_reg;
        s1_valid_next     = 1'b0;
        s2_valid_next     = 1'b0;
        res_next          = res_reg;
        res_valid_next    = res_valid_reg && res_stall;
        vtx_stall         = 1'b1;
        buf_we            = 1'b0;
        rd_en             = 1'b0;
        wr_en             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                vtx_stall = 1'b0;
                if (vtx_valid)
                begin
                    stored_count_next = cnt_base;
                    buf_we            = (ac < AC_FULL);
                    attr_cnt_next     = ac_inc;
                    if (vtx.end_of_vertex)
                    begin
                        attr_cnt_next = '0;
                        if (ac_inc != AC_FULL)
                        begin
                            pend_next.vertex_index = '0;
                            pend_next.is_new       = 1'b0;
                            pend_next.unique_count = cnt_base;
                            pend_next.status       = STATUS_BAD_COUNT;
                            pend_append_next       = 1'b0;
                            state_next             = ST_EMIT;
                        end
                        else if (cnt_base == '0)
                        begin
                            pend_next.vertex_index = '0;
                            pend_next.is_new       = 1'b1;
                            pend_next.unique_count = CNT_W'(1);
                            pend_next.status       = STATUS_OK;
                            pend_append_next       = 1'b1;
                            state_next             = ST_EMIT;
                        end
                        else
                        begin
                            scan_cnt_next = '0;
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (s2_valid_reg && row_hit)
                begin
                    pend_next.vertex_index = {{(CNT_W - IDX_W){1'b0}}, s2_idx_reg};
                    pend_next.is_new       = 1'b0;
                    pend_next.unique_count = stored_count_reg;
                    pend_next.status       = STATUS_OK;
                    pend_append_next       = 1'b0;
                    state_next             = ST_EMIT;
                end
                else if (scan_cnt_reg == stored_count_reg && !s1_valid_reg)
                begin
                    if (stored_count_reg < CNT_MAX)
                    begin
                        pend_next.vertex_index = stored_count_reg;
                        pend_next.is_new       = 1'b1;
                        pend_next.unique_count = stored_count_reg + CNT_W'(1);
                        pend_next.status       = STATUS_OK;
                        pend_append_next       = 1'b1;
                    end
                    else
                    begin
                        pend_next.vertex_index = CNT_MAX;
                        pend_next.is_new       = 1'b0;
                        pend_next.unique_count = stored_count_reg;
                        pend_next.status       = STATUS_FULL;
                        pend_append_next       = 1'b0;
                    end
                    state_next = ST_EMIT;
                end
                else
                begin
                    s2_valid_next = s1_valid_reg;
                    if (scan_cnt_reg != stored_count_reg)
                    begin
                        rd_en         = 1'b1;
                        s1_valid_next = 1'b1;
                        scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = pend_reg;
                    if (pend_append_reg)
                    begin
                        wr_en             = 1'b1;
                        stored_count_next = stored_count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            attr_cnt_reg     <= '0;
            stored_count_reg <= '0;
            scan_cnt_reg     <= '0;
            tol_reg          <= TOL_RESET;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            pend_append_reg  <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            attr_cnt_reg     <= attr_cnt_next;
            stored_count_reg <= stored_count_next;
            scan_cnt_reg     <= scan_cnt_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            pend_append_reg  <= pend_append_next;
            res_valid_reg    <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        res_reg    <= res_next;
        s1_idx_reg <= scan_cnt_reg[IDX_W-1:0];
        s2_idx_reg <= s1_idx_reg;
        if (buf_we)
        begin
            buf_reg[buf_slot] <= vtx.attr_bits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[stored_count_reg[IDX_W-1:0]] <= buf_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[scan_cnt_reg[IDX_W-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_count_reg <= CNT_MAX)
        else $error("stored count beyond table size");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || s2_valid_reg) |-> state_reg == ST_SCAN)
        else $error("scan pipeline busy outside scan");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> {{(CNT_W - IDX_W){1'b0}}, s1_idx_reg} < stored_count_reg)
        else $error("row read beyond stored count");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emit");

endmodule

### verif/vertex_dedup_ulp_match_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex deduplication testbench
// Streams attribute transactions into the block and predicts each vertex
// result from a local copy of the unique table, the gather buffer and the
// tolerance. It covers signed zeros, tolerance edges, bad attribute counts,
// a full table and random mesh traffic under sender gaps and result stalls.
// ----------------------------------------------------------------------------
module vertex_dedup_ulp_match_test;
    import vdd_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RX_FREE       = 0;
    localparam int RX_RANDOM     = 1;
    localparam int RX_PATTERN    = 2;
    localparam logic [TOL_W-1:0]  TOL_MAX   = '1;
    localparam logic [ATTR_W-1:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
    localparam logic [ATTR_W-1:0] MAG_BITS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [ATTR_W-1:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
    localparam logic [ATTR_W-1:0] ONE_DBL   = 64'h3FF0_0000_0000_0000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             vtx_valid = 1'b0;
    logic             vtx_stall;
    vdd_in_t          vtx       = '0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    vdd_out_t         res;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [TOL_W-1:0] cfg_data  = '0;

    vertex_dedup_ulp_match uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .vtx_valid (vtx_valid),
        .vtx_stall (vtx_stall),
        .vtx       (vtx),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    row_t             uniq_rows [MAX_UNIQUE];
    row_t             vtx_words;
    int               uniq_count = 0;
    int               attr_cnt   = 0;
    logic [TOL_W-1:0] tolerance  = TOL_RESET;
    vdd_out_t         dedup_answers [$];
    row_t             mesh_rows [$];
    vdd_out_t         want_res;

    int errors       = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int tol_writes   = 0;
    int peak_count   = 0;
    int cycle_count  = 0;

    bit pace_on     = 1'b1;
    int burst_left  = 0;
    bit rx_on       = 1'b1;
    int rx_mode     = RX_FREE;
    int rx_span     = 0;
    int rx_phase    = 0;
    int hold_left   = 0;
    int hold_cycles = 0;
    bit hold_go     = 1'b0;
    bit hold_seen   = 1'b0;

    function automatic bit within_ulps(logic [ATTR_W-1:0] a, logic [ATTR_W-1:0] b);
        logic [ATTR_W-1:0] diff;
        logic [ATTR_W-1:0] lim;
        diff = a - b;
        lim  = ATTR_W'(tolerance);
        if (a[ATTR_W-1] != b[ATTR_W-1])
            return ((a | b) & MAG_BITS) == '0;
        return (diff <= lim) || ((ATTR_W'(0) - diff) <= lim);
    endfunction

    function automatic bit rows_match(row_t a, row_t b);
        int k;
        for (k = 0; k < ATTR_SLOTS; k++)
            if (!within_ulps(a[k], b[k]))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic dedup_step(input vdd_in_t item);
        vdd_out_t r;
        int       e;
        int       found;
        if (item.new_mesh)
        begin
            uniq_count = 0;
            attr_cnt   = 0;
        end
        if (attr_cnt < ATTR_SLOTS)
            vtx_words[attr_cnt] = item.attr_bits;
        if (attr_cnt < int'(AC_SAT))
            attr_cnt++;
        if (item.end_of_vertex)
        begin
            r        = '0;
            r.status = STATUS_OK;
            if (attr_cnt != ATTR_SLOTS)
                r.status = STATUS_BAD_COUNT;
            else
            begin
                found = -1;
                for (e = 0; e < uniq_count && found < 0; e++)
                    if (rows_match(vtx_words, uniq_rows[e]))
                        found = e;
                if (found >= 0)
                    r.vertex_index = CNT_W'(found);
                else if (uniq_count < MAX_UNIQUE)
                begin
                    uniq_rows[uniq_count] = vtx_words;
                    r.vertex_index = CNT_W'(uniq_count);
                    r.is_new = 1'b1;
                    uniq_count++;
                end
                else
                begin
                    r.vertex_index = CNT_W'(MAX_UNIQUE);
                    r.status = STATUS_FULL;
                end
            end
            attr_cnt = 0;
            r.unique_count = CNT_W'(uniq_count);
            if (uniq_count > peak_count)
                peak_count = uniq_count;
            dedup_answers.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch %0d at cycle %0d: %s got %0d expected %0d",
                     errors, cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (dedup_answers.size() == 0)
                report_mismatch("result with nothing pending, index",
                                64'(res.vertex_index), 64'd0);
            else
            begin
                want_res = dedup_answers.pop_front();
                if (res.vertex_index !== want_res.vertex_index)
                    report_mismatch("vertex_index", 64'(res.vertex_index),
                                    64'(want_res.vertex_index));
                if (res.is_new !== want_res.is_new)
                    report_mismatch("is_new", 64'(res.is_new), 64'(want_res.is_new));
                if (res.unique_count !== want_res.unique_count)
                    report_mismatch("unique_count", 64'(res.unique_count),
                                    64'(want_res.unique_count));
                if (res.status !== want_res.status)
                    report_mismatch("status", 64'(res.status), 64'(want_res.status));
            end
        end
    end

    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1;
        if (hold_go != hold_seen)
        begin
            hold_seen <= hold_go;
            hold_left <= hold_cycles;
            res_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else if (!rx_on)
            res_stall <= 1'b0;
        else
        begin
            if (rx_span == 0)
            begin
                rx_mode <= $urandom_range(RX_FREE, RX_PATTERN);
                rx_span <= $urandom_range(20, 300);
            end
            else
                rx_span <= rx_span - 1;
            case (rx_mode)
                RX_FREE:   res_stall <= 1'b0;
                RX_RANDOM: res_stall <= ($urandom_range(0, 99) < 35);
                default:   res_stall <= ((rx_phase % 7) < 3);
            endcase
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic logic [ATTR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ATTR_W-1:0] rand_attr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 16)
            return NEG_ZERO;
        if (r < 22)
            return ATTR_W'($urandom_range(1, 40));
        if (r < 26)
            return '1;
        if (r < 30)
            return QUIET_NAN;
        return rand64();
    endfunction

    function automatic row_t rand_row();
        row_t w;
        int   k;
        for (k = 0; k < ATTR_SLOTS; k++)
            w[k] = rand_attr();
        return w;
    endfunction

    function automatic row_t flat_row(logic [ATTR_W-1:0] v);
        row_t w;
        int   k;
        for (k = 0; k < ATTR_SLOTS; k++)
            w[k] = v;
        return w;
    endfunction

    task automatic send_item(input logic [ATTR_W-1:0] bits, input logic eov, input logic nm);
        vdd_in_t item;
        int      gap;
        item.attr_bits     = bits;
        item.end_of_vertex = eov;
        item.new_mesh      = nm;
        if (pace_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 10);
                burst_left = $urandom_range(1, 24);
                vtx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left--;
        end
        vtx_valid <= 1'b1;
        vtx       <= item;
        @(posedge clk);
        while (vtx_stall)
            @(posedge clk);
        dedup_step(item);
        items_sent++;
    endtask

    task automatic send_vertex(input row_t w, input int n, input logic nm);
        int i;
        for (i = 0; i < n; i++)
        begin
            if (i < ATTR_SLOTS)
                send_item(w[i], i == n - 1, nm && i == 0);
            else
                send_item(rand64(), i == n - 1, 1'b0);
        end
    endtask

    task automatic wait_drained();
        vtx_valid <= 1'b0;
        while (dedup_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_tolerance(input logic [TOL_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tolerance = v;
        tol_writes++;
    endtask

    task automatic test_signed_zero_and_extremes();
        row_t w;
        send_vertex(flat_row('0), ATTR_SLOTS, 1'b1);
        send_vertex(flat_row(NEG_ZERO), ATTR_SLOTS, 1'b0);
        send_vertex(flat_row('1), ATTR_SLOTS, 1'b0);
        w = flat_row('1);
        w[ATTR_SLOTS-1] = '1 - ATTR_W'(24);
        send_vertex(w, ATTR_SLOTS, 1'b0);
        w[ATTR_SLOTS-1] = '1 - ATTR_W'(25);
        send_vertex(w, ATTR_SLOTS, 1'b0);
        send_vertex(flat_row(NEG_ZERO | 64'd1), ATTR_SLOTS, 1'b0);
        send_vertex(flat_row(MAG_BITS), ATTR_SLOTS, 1'b0);
        wait_drained();
    endtask

    task automatic test_attribute_counts();
        int i;
        send_vertex(rand_row(), 1, 1'b0);
        send_vertex(rand_row(), ATTR_SLOTS - 1, 1'b0);
        send_vertex(rand_row(), ATTR_SLOTS + 1, 1'b0);
        send_vertex(rand_row(), 40, 1'b0);
        for (i = 0; i < 5; i++)
            send_item(rand64(), 1'b0, 1'b0);
        send_vertex(flat_row('0), ATTR_SLOTS, 1'b1);
        send_item(rand64(), 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_tolerance_extremes();
        row_t base;
        row_t w;
        base    = rand_row();
        base[0] = 64'h4008_0000_0000_0000;
        base[3] = ONE_DBL;
        base[5] = ONE_DBL;
        set_tolerance('0);
        send_vertex(base, ATTR_SLOTS, 1'b1);
        w = base;
        w[3] = ONE_DBL + 64'd1;
        send_vertex(w, ATTR_SLOTS, 1'b0);
        send_vertex(base, ATTR_SLOTS, 1'b0);
        set_tolerance(TOL_MAX);
        w = base;
        w[5] = ONE_DBL + ATTR_W'(TOL_MAX);
        send_vertex(w, ATTR_SLOTS, 1'b0);
        w[5] = ONE_DBL - ATTR_W'(TOL_MAX);
        send_vertex(w, ATTR_SLOTS, 1'b0);
        w[5] = ONE_DBL + ATTR_W'(TOL_MAX) + 64'd1;
        send_vertex(w, ATTR_SLOTS, 1'b0);
        w = base;
        w[0][ATTR_W-1] = 1'b1;
        send_vertex(w, ATTR_SLOTS, 1'b0);
        wait_drained();
    endtask

    task automatic test_output_hold();
        row_t w;
        int   i;
        w = rand_row();
        pace_on     = 1'b0;
        hold_cycles = 500;
        hold_go     = ~hold_go;
        for (i = 0; i < 6; i++)
            send_vertex((i % 2 == 0) ? w : rand_row(), ATTR_SLOTS, i == 0);
        pace_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_table_full();
        row_t w;
        row_t keep;
        int   n;
        set_tolerance(TOL_RESET);
        pace_on = 1'b0;
        rx_on   = 1'b0;
        for (n = 0; n < MAX_UNIQUE; n++)
        begin
            w    = rand_row();
            w[0] = ONE_DBL + (ATTR_W'(n) << 24);
            if (n == 700)
                keep = w;
            send_vertex(w, ATTR_SLOTS, n == 0);
        end
        w    = keep;
        w[7] = w[7] + 64'd20;
        send_vertex(w, ATTR_SLOTS, 1'b0);
        w    = rand_row();
        w[0] = 64'hBFF0_0000_0000_0000;
        send_vertex(w, ATTR_SLOTS, 1'b0);
        send_vertex(rand_row(), ATTR_SLOTS - 3, 1'b0);
        rx_on   = 1'b1;
        pace_on = 1'b1;
        send_vertex(rand_row(), ATTR_SLOTS, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        row_t              w;
        logic [ATTR_W-1:0] step;
        int                start;
        int                kind;
        int                n;
        int                k;
        int                tol;
        bit                nm;
        bit                paused;
        start  = items_sent;
        paused = 1'b0;
        tol    = int'(tolerance);
        mesh_rows.delete();
        while (items_sent - start < n_items)
        begin
            kind = $urandom_range(0, 99);
            nm   = ($urandom_range(0, 29) == 0);
            n    = ATTR_SLOTS;
            if (nm)
                mesh_rows.delete();
            if (kind < 15 || mesh_rows.size() == 0)
                w = rand_row();
            else if (kind < 85)
            begin
                w = mesh_rows[$urandom_range(0, mesh_rows.size() - 1)];
                case ($urandom_range(0, 2))
                    0: ;
                    1:
                    begin
                        for (k = 0; k < ATTR_SLOTS; k++)
                        begin
                            if ($urandom_range(0, 1))
                            begin
                                step = ATTR_W'($urandom_range(0, 2 * tol)) - ATTR_W'(tol);
                                w[k] = w[k] + step;
                            end
                            if ((w[k] & MAG_BITS) == '0)
                                w[k][ATTR_W-1] = 1'($urandom_range(0, 1));
                        end
                    end
                    default:
                    begin
                        k    = $urandom_range(0, ATTR_SLOTS - 1);
                        step = ATTR_W'(tol) + 64'd1;
                        w[k] = $urandom_range(0, 1) ? w[k] + step : w[k] - step;
                    end
                endcase
            end
            else if (kind < 93)
            begin
                w = rand_row();
                n = $urandom_range(0, 1) ? $urandom_range(1, ATTR_SLOTS - 1)
                                         : $urandom_range(ATTR_SLOTS + 1, 36);
            end
            else
            begin
                for (k = $urandom_range(1, 20); k > 0; k--)
                    send_item(rand64(), 1'b0, 1'b0);
                w  = rand_row();
                nm = 1'b1;
                mesh_rows.delete();
            end
            send_vertex(w, n, nm);
            if (n == ATTR_SLOTS && mesh_rows.size() < 64)
                mesh_rows.push_back(w);
            if (!paused && items_sent - start >= n_items / 2)
            begin
                wait_drained();
                paused = 1'b1;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_signed_zero_and_extremes();
        test_attribute_counts();
        test_tolerance_extremes();
        test_output_hold();
        test_table_full();
        set_tolerance(TOL_RESET);
        test_random_traffic(275);
        set_tolerance('0);
        test_random_traffic(275);
        set_tolerance(TOL_MAX);
        test_random_traffic(275);
        set_tolerance(TOL_W'($urandom_range(1, int'(TOL_MAX) - 1)));
        test_random_traffic(275);
        wait_drained();
        repeat (20) @(posedge clk);
        $display("run covered %0d attribute transactions, %0d vertex results, %0d tolerance writes",
                 items_sent, results_seen, tol_writes);
        $display("unique table peaked at %0d of %0d rows, %0d mismatches",
                 peak_count, MAX_UNIQUE, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
